[rtl/arst_pkg.sv]
// Package for the address range symbol table: types, constants, command codes.
`default_nettype none
package arst_pkg;
	localparam int TABLE_DEPTH_DEF = 8192;
	localparam int TAG_BITS_DEF = 16;
	localparam logic [31:0] SPAN_RESET = 32'h0000_1000;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		REG_BIAS = 1'b0,
		REG_SPAN = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WAIT,
		ST_INS_MOVE,
		ST_INS_PUT,
		ST_LK_RD,
		ST_LK_WAIT,
		ST_LK_CMP,
		ST_LK_BEST,
		ST_LK_NEXT,
		ST_LK_NWAIT,
		ST_LK_FIN,
		ST_RD_WAIT,
		ST_RD_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] addr;
		logic [31:0] extent;
		logic [15:0] tag;
		logic [12:0] num;
	} cmd_beat_t;

	typedef struct packed {
		logic        hit;
		logic [12:0] index;
		logic [15:0] tag;
		logic [31:0] offset;
		logic [31:0] start;
		logic [31:0] extent;
		logic [13:0] total;
		logic        full;
	} result_t;
endpackage
`default_nettype wire

[rtl/arst_front.sv]
// Front end: accepts command beats, applies bias to inserts, queues all beats.
`default_nettype none
module arst_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  arst_pkg::cmd_beat_t  in_beat,
	input  wire  [31:0]          bias,
	output logic                 q_valid,
	input  wire                  q_ready,
	output arst_pkg::cmd_beat_t  q_beat
);
	import arst_pkg::*;

	cmd_beat_t buf_q [2];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_beat_t cls;
	logic      push, pop;

	always_comb begin
		cls = in_beat;
		if (in_beat.cmd == CMD_INSERT) begin
			cls.addr = in_beat.addr + bias;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_beat = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

[rtl/arst_back.sv]
// Back end: sorted table memory, insert shifter and binary-search lookup.
`default_nettype none
module arst_back #(
	parameter int TABLE_DEPTH = arst_pkg::TABLE_DEPTH_DEF,
	parameter int TAG_BITS = arst_pkg::TAG_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	output logic                 q_ready,
	input  arst_pkg::cmd_beat_t  q_beat,
	input  wire  [31:0]          span,
	output logic                 res_valid,
	input  wire                  res_ready,
	output arst_pkg::result_t    res
);
	import arst_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 64 + TAG_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [EW-1:0] mem [TABLE_DEPTH];
	logic [EW-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [EW-1:0] wdata;

	state_t state_q, state_d;
	cmd_beat_t cmd_q;
	logic [CW-1:0] count_q, lo_q, hi_q, pos_q;
	logic [EW-1:0] best_q;
	result_t res_q;
	result_t res_out_q;
	logic res_v_q;

	logic [31:0] r_start, r_ext, b_start, b_ext;
	logic [CW-1:0] mid;
	assign r_start = rdata_q[31:0];
	assign r_ext = rdata_q[63:32];
	assign b_start = best_q[31:0];
	assign b_ext = best_q[63:32];
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_beat.cmd)
						CMD_CLEAR:  state_d = ST_DONE;
						CMD_INSERT: state_d = (count_q >= DEPTH_C) ? ST_DONE :
							(count_q == '0) ? ST_INS_PUT : ST_INS_RD;
						CMD_LOOKUP: state_d = (count_q == '0) ? ST_DONE : ST_LK_RD;
						CMD_READ:   state_d = (32'(q_beat.num) < 32'(count_q)) ?
							ST_RD_WAIT : ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD:   state_d = ST_INS_WAIT;
			ST_INS_WAIT: state_d = (r_start > cmd_q.addr) ? ST_INS_MOVE : ST_INS_PUT;
			ST_INS_MOVE: state_d = (pos_q == CW'(1)) ? ST_INS_PUT : ST_INS_RD;
			ST_INS_PUT:  state_d = ST_DONE;
			ST_LK_RD:    state_d = (lo_q < hi_q) ? ST_LK_WAIT : ST_LK_BEST;
			ST_LK_WAIT:  state_d = ST_LK_CMP;
			ST_LK_CMP:   state_d = ST_LK_RD;
			ST_LK_BEST:  state_d = (lo_q == '0) ? ST_DONE : ST_LK_NEXT;
			ST_LK_NEXT:  state_d = ST_LK_NWAIT;
			ST_LK_NWAIT: state_d = ST_LK_FIN;
			ST_LK_FIN:   state_d = ST_DONE;
			ST_RD_WAIT:  state_d = ST_RD_FIN;
			ST_RD_FIN:   state_d = ST_DONE;
			ST_DONE:     state_d = (res_ready || !res_valid) ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (state_q == ST_IDLE);
		we = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = {cmd_q.tag[TAG_BITS-1:0], cmd_q.extent, cmd_q.addr};
		raddr = mid[AW-1:0];
		unique case (state_q)
			ST_IDLE:     raddr = AW'(q_beat.num);
			// hold the address so rdata_q still has the entry to shift
			ST_INS_RD, ST_INS_WAIT: raddr = AW'(pos_q - CW'(1));
			ST_INS_MOVE: begin
				we = 1'b1;
				wdata = rdata_q;
			end
			ST_INS_PUT:  we = 1'b1;
			ST_LK_NEXT:  raddr = lo_q[AW-1:0];
			ST_RD_WAIT:  raddr = AW'(cmd_q.num);
			default:     ;
		endcase
	end

	assign res_valid = res_v_q;
	assign res = res_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_v_q && res_ready) res_v_q <= 1'b0;
			if (state_q == ST_DONE && (res_ready || !res_v_q)) res_v_q <= 1'b1;
			if (state_q == ST_IDLE && q_valid) begin
				if (q_beat.cmd == CMD_CLEAR) count_q <= '0;
			end
			if (state_q == ST_INS_PUT) count_q <= count_q + CW'(1);
		end
	end

	// output register: the next command works on res_q while this beat waits
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (res_ready || !res_v_q)) res_out_q <= res_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= q_beat;
				pos_q <= count_q;
				lo_q <= '0;
				hi_q <= count_q;
				res_q <= '{hit: 1'b0, index: '0, tag: '0, offset: '0, start: '0,
					extent: '0,
					total: (q_beat.cmd == CMD_CLEAR) ? 14'd0 : 14'(count_q),
					full: (q_beat.cmd == CMD_INSERT) && (count_q >= DEPTH_C)};
			end
			ST_INS_MOVE: pos_q <= pos_q - CW'(1);
			ST_INS_PUT:  res_q.total <= 14'(count_q + CW'(1));
			ST_LK_CMP: begin
				if (r_start <= cmd_q.addr) begin
					lo_q <= mid + CW'(1);
					best_q <= rdata_q;
				end else begin
					hi_q <= mid;
				end
			end
			ST_LK_NWAIT: ;
			ST_LK_FIN: begin
				if (cmd_q.addr < ((b_ext != 32'd0) ? b_start + b_ext :
					(lo_q < count_q) ? r_start : b_start + span)) begin
					res_q.hit <= 1'b1;
					res_q.index <= 13'(lo_q - CW'(1));
					res_q.tag <= 16'(best_q[EW-1:64]);
					res_q.offset <= cmd_q.addr - b_start;
					res_q.start <= b_start;
					res_q.extent <= b_ext;
				end
			end
			ST_RD_FIN: begin
				res_q.hit <= 1'b1;
				res_q.index <= cmd_q.num;
				res_q.tag <= 16'(rdata_q[EW-1:64]);
				res_q.start <= r_start;
				res_q.extent <= r_ext;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/address_range_symbol_table.sv]
// Top level of the address range symbol table.
// Commands: clear, read, binary-search lookup with about log2(entries)+1 probes, and
// insert, which sorts the new entry in by shifting each larger entry up one place
// through the table memory (one read port and one write port).
// Throughput: one command at a time in the back end; a two-beat queue buffers the front,
// an output register holds a stalled result while the next command runs.
// Reset: arst_n clears the entry count, queue and FSM; table memory is not cleared.
`default_nettype none
module address_range_symbol_table #(
	parameter int TABLE_DEPTH = arst_pkg::TABLE_DEPTH_DEF,
	parameter int TAG_BITS = arst_pkg::TAG_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [0:0]   cfg_index,
	input  wire  [31:0]  cfg_data,
	input  wire          s_tvalid,
	output logic         s_tready,
	// tdata: query_addr[31:0], extent[63:32], tag[79:64], entry_number[92:80], pad
	input  wire  [95:0]  s_tdata,
	// tuser: command
	input  wire  [1:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// tdata: found_index, found_tag, found_offset, found_start, found_extent,
	// entry_total, table_full, pad
	output logic [143:0] m_tdata,
	// tuser: hit
	output logic [0:0]   m_tuser
);
	import arst_pkg::*;

	logic [31:0] bias_q, span_q;
	cmd_beat_t in_beat, q_beat;
	logic q_valid, q_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			span_q <= SPAN_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BIAS: bias_q <= cfg_data;
				REG_SPAN: span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_beat = '{cmd: cmd_t'(s_tuser), addr: s_tdata[31:0], extent: s_tdata[63:32],
		tag: s_tdata[79:64], num: s_tdata[92:80]};

	arst_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_beat(in_beat), .bias(bias_q), .q_valid(q_valid), .q_ready(q_ready),
		.q_beat(q_beat)
	);

	arst_back #(.TABLE_DEPTH(TABLE_DEPTH), .TAG_BITS(TAG_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_beat(q_beat), .span(span_q), .res_valid(m_tvalid), .res_ready(m_tready),
		.res(res)
	);

	assign m_tuser = res.hit;
	assign m_tdata = {4'b0, res.full, res.total, res.extent, res.start, res.offset,
		res.tag, res.index};

	// a result never carries a hit together with a full flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.hit && res.full))
		else $error("hit and full together");
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed under stall");
endmodule
`default_nettype wire

[tb/address_range_symbol_table_checker.sv]
// Checker for the address range symbol table: table predictor and result scoreboard.
`default_nettype none
module address_range_symbol_table_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [0:0]   cfg_index,
	input  wire  [31:0]  cfg_data,
	input  wire          s_tvalid,
	input  wire          s_tready,
	input  wire  [95:0]  s_tdata,
	input  wire  [1:0]   s_tuser,
	input  wire          m_tvalid,
	input  wire          m_tready,
	input  wire  [143:0] m_tdata,
	input  wire  [0:0]   m_tuser,
	output int           fail_count,
	output int           pending
);
	import arst_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;

	logic [31:0] tbl_start [DEPTH];
	logic [31:0] tbl_extent[DEPTH];
	logic [15:0] tbl_tag   [DEPTH];
	int          tbl_count;
	logic [31:0] bias;
	logic [31:0] span;
	result_t     expected_q[$];

	function automatic result_t entry_result(int idx, logic [31:0] offset);
		result_t r;
		r = '0;
		r.hit    = 1'b1;
		r.index  = idx[12:0];
		r.tag    = tbl_tag[idx];
		r.offset = offset;
		r.start  = tbl_start[idx];
		r.extent = tbl_extent[idx];
		return r;
	endfunction

	// Apply one command beat to the table copy and return what the block should answer.
	function automatic result_t predict_table(cmd_t cmd, logic [31:0] addr, logic [31:0] ext,
			logic [15:0] tg, logic [12:0] num);
		result_t     r;
		int          pos;
		int          lo;
		int          hi;
		int          mid;
		int          best;
		logic [31:0] key;
		logic [31:0] limit;
		r = '0;
		case (cmd)
			CMD_CLEAR: begin
				tbl_count = 0;
			end
			CMD_INSERT: begin
				if (tbl_count >= DEPTH) begin
					r.full = 1'b1;
				end else begin
					key = addr + bias;
					pos = tbl_count;
					// stable: new entry lands after equal starts
					while (pos > 0 && tbl_start[pos-1] > key) begin
						tbl_start[pos]  = tbl_start[pos-1];
						tbl_extent[pos] = tbl_extent[pos-1];
						tbl_tag[pos]    = tbl_tag[pos-1];
						pos--;
					end
					tbl_start[pos]  = key;
					tbl_extent[pos] = ext;
					tbl_tag[pos]    = tg;
					tbl_count++;
				end
			end
			CMD_LOOKUP: begin
				lo = 0;
				hi = tbl_count;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (tbl_start[mid] <= addr) lo = mid + 1;
					else hi = mid;
				end
				if (lo > 0) begin
					best = lo - 1;
					if (tbl_extent[best] != 0) limit = tbl_start[best] + tbl_extent[best];
					else if (best + 1 < tbl_count) limit = tbl_start[best+1];
					else limit = tbl_start[best] + span;
					if (addr < limit) r = entry_result(best, addr - tbl_start[best]);
				end
			end
			default: begin
				if (int'(num) < tbl_count) r = entry_result(int'(num), 32'd0);
			end
		endcase
		r.total = tbl_count[13:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			tbl_count  = 0;
			bias       = '0;
			span       = SPAN_RESET;
			fail_count = 0;
			pending    <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BIAS) bias = cfg_data;
				else span = cfg_data;
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_table(cmd_t'(s_tuser), s_tdata[31:0],
					s_tdata[63:32], s_tdata[79:64], s_tdata[92:80]));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					check_field("hit", 32'(exp_r.hit), 32'(m_tuser[0]));
					check_field("found_index", 32'(exp_r.index), 32'(m_tdata[12:0]));
					check_field("found_tag", 32'(exp_r.tag), 32'(m_tdata[28:13]));
					check_field("found_offset", exp_r.offset, m_tdata[60:29]);
					check_field("found_start", exp_r.start, m_tdata[92:61]);
					check_field("found_extent", exp_r.extent, m_tdata[124:93]);
					check_field("entry_total", 32'(exp_r.total), 32'(m_tdata[138:125]));
					check_field("table_full", 32'(exp_r.full), 32'(m_tdata[139]));
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule
`default_nettype wire

[tb/address_range_symbol_table_test.sv]
// Testbench top: stimulus, handshake pressure and verdict for the symbol table.
`default_nettype none
module address_range_symbol_table_test;
	import arst_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int IDLE_LIMIT = 200000;  // worst insert shifts a full table
	localparam int PHASE_ITEMS = 340;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [0:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// tdata: query_addr[31:0], extent[63:32], tag[79:64], entry_number[92:80], pad
	logic [95:0]  s_tdata = '0;
	// tuser: command
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// tdata: found_index, found_tag, found_offset, found_start, found_extent,
	// entry_total, table_full, pad
	logic [143:0] m_tdata;
	// tuser: hit
	logic [0:0]   m_tuser;

	int          fail_count;
	int          pending;
	bit          send_gaps;   // sender idles in bursts
	bit          recv_stalls; // receiver stalls in bursts
	bit          long_hold;   // receiver request for one long hold-off
	logic [31:0] cur_bias;
	logic [31:0] held_starts[$]; // biased starts inserted since the last clear

	always #10 clk = ~clk;

	address_range_symbol_table u_top (.*);

	address_range_symbol_table_checker u_chk (.*);

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog: cycles in a row with no beat on either side.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// One command beat; returns at the edge where it is taken.
	task automatic send_cmd(cmd_t cmd, logic [31:0] addr, logic [31:0] ext,
			logic [15:0] tg, logic [12:0] num);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, num, tg, ext, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd == CMD_CLEAR) held_starts.delete();
		if (cmd == CMD_INSERT && held_starts.size() < DEPTH) held_starts.push_back(addr + cur_bias);
	endtask

	// Drain everything, then let the back end settle before touching registers.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_BIAS) cur_bias = val;
	endtask

	function automatic logic [31:0] rand_extent();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return $urandom_range(1, 64);
			2: return $urandom_range(1, 4096);
			default: return $urandom();
		endcase
	endfunction

	// Random mix: mostly inserts and lookups that land near held entries.
	task automatic random_items(int count);
		int          k;
		int          pick;
		logic [31:0] a;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3 || (held_starts.size() > 48 && pick < 10)) begin
				send_cmd(CMD_CLEAR, $urandom(), $urandom(), 16'($urandom()), 13'($urandom()));
			end else if (pick < 40) begin
				a = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 255)) << 6;
				send_cmd(CMD_INSERT, a, rand_extent(), 16'($urandom()), 13'($urandom()));
			end else if (pick < 82) begin
				if (held_starts.size() > 0 && $urandom_range(0, 3) != 0)
					a = held_starts[$urandom_range(0, held_starts.size() - 1)]
						+ $urandom_range(0, 80) - 8;
				else
					a = $urandom();
				send_cmd(CMD_LOOKUP, a, $urandom(), 16'($urandom()), 13'($urandom()));
			end else begin
				send_cmd(CMD_READ, $urandom(), $urandom(), 16'($urandom()),
					($urandom_range(0, 3) == 0) ? 13'($urandom()) : 13'($urandom_range(0, 60)));
			end
		end
	endtask

	initial begin
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;
		long_hold   = 1'b0;
		cur_bias    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unsized last entry, equal starts, wrapping end.
		send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_READ, 32'h0, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_INSERT, 32'h0, 32'h0, 16'h1234, 13'd0);
		send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_LOOKUP, 32'hFFF, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_LOOKUP, 32'h1000, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 13'h1FFF);
		send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_INSERT, 32'h0, 32'h20, 16'h0001, 13'd0);
		send_cmd(CMD_INSERT, 32'h0, 32'h0, 16'h0002, 13'd0);
		send_cmd(CMD_INSERT, 32'h100, 32'h10, 16'h0003, 13'd0);
		send_cmd(CMD_READ, 32'h0, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_READ, 32'h0, 32'h0, 16'h0, 13'd1);
		send_cmd(CMD_READ, 32'h0, 32'h0, 16'h0, 13'd2);
		send_cmd(CMD_READ, 32'h0, 32'h0, 16'h0, 13'h1FFF);
		send_cmd(CMD_LOOKUP, 32'h50, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_LOOKUP, 32'h10F, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_LOOKUP, 32'h110, 32'h0, 16'h0, 13'd0);
		send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 13'h1FFF);
		send_cmd(CMD_LOOKUP, 32'h50, 32'h0, 16'h0, 13'd0);

		// Receiver holds off while the sender keeps offering: input must stall.
		long_hold = 1'b1;
		random_items(40);

		// Sender pauses until every result is back, then the registers move.
		drain();
		write_reg(REG_BIAS, $urandom());
		write_reg(REG_SPAN, $urandom_range(0, 300));
		random_items(PHASE_ITEMS);

		drain();
		write_reg(REG_BIAS, 32'hFFFF_FFFF);
		write_reg(REG_SPAN, 32'hFFFF_FFFF);
		random_items(PHASE_ITEMS);

		// Zero bias and zero span from an empty table.
		drain();
		write_reg(REG_BIAS, 32'h0);
		write_reg(REG_SPAN, 32'h0);
		send_cmd(CMD_CLEAR, 32'h0, 32'h0, 16'h0, 13'd0);
		random_items(PHASE_ITEMS);

		drain();
		write_reg(REG_BIAS, $urandom());
		write_reg(REG_SPAN, 32'h0000_1000);
		random_items(PHASE_ITEMS);

		// Closing stretch at full rate on both sides.
		drain();
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		write_reg(REG_SPAN, $urandom());
		random_items(PHASE_ITEMS);

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
